// ===== sv/pmct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared types and constants of the cursor tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

  // Port widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OutW     = 12;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegGraphical = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWidth     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeight    = 2'd2;

  // Register reset values
  localparam logic [CfgDataW-1:0] WidthRst  = 13'd1024;
  localparam logic [CfgDataW-1:0] HeightRst = 13'd768;

  // Flag byte sign bits of the deltas
  localparam int unsigned FlagSignX = 4;
  localparam int unsigned FlagSignY = 5;

  // Text mode accumulator steps and saturation limits
  localparam logic signed [15:0] AccStepX = 16'sd4;
  localparam logic signed [15:0] AccStepY = 16'sd8;
  localparam logic signed [16:0] AccMax   = 17'sd32767;
  localparam logic signed [16:0] AccMin   = -17'sd32768;

  // Packet queue depth
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic signed [8:0] dx;
    logic signed [9:0] dy;
    logic              zero;
  } packet_t;

  typedef struct packed {
    logic                graphical;
    logic [CfgDataW-1:0] width;
    logic [CfgDataW-1:0] height;
  } cfg_t;

endpackage

// ===== sv/pmct_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet assembler
// Groups mouse bytes into flags, delta X and delta Y and forms signed deltas.
// ----------------------------------------------------------------------------
module pmct_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          byte_valid_i,
  output logic                          byte_ready_o,
  input  logic [pmct_pkg::ByteW-1:0]    byte_i,
  output logic                          push_o,
  output pmct_pkg::packet_t             pkt_o,
  input  logic                          q_full_i
);
  import pmct_pkg::*;

  localparam logic [1:0] IdxFlags = 2'd0;
  localparam logic [1:0] IdxDx    = 2'd1;
  localparam logic [1:0] IdxDy    = 2'd2;

  logic [1:0]       idx_q, idx_d;
  logic [ByteW-1:0] flags_q, flags_d;
  logic [ByteW-1:0] dx_q, dx_d;
  logic             take;
  logic signed [8:0] dy_raw;

  assign byte_ready_o = (idx_q != IdxDy) || !q_full_i;
  assign take         = byte_valid_i && byte_ready_o;

  assign dy_raw    = signed'({flags_q[FlagSignY], byte_i});
  assign pkt_o.dx  = signed'({flags_q[FlagSignX], dx_q});
  assign pkt_o.dy  = -(10'(dy_raw));
  assign pkt_o.zero = (dx_q == '0) && !flags_q[FlagSignX] && (byte_i == '0)
                      && !flags_q[FlagSignY];

  always_comb begin
    idx_d   = idx_q;
    flags_d = flags_q;
    dx_d    = dx_q;
    push_o  = 1'b0;
    if (clear_i) begin
      idx_d   = IdxFlags;
      flags_d = '0;
      dx_d    = '0;
    end else if (take) begin
      case (idx_q)
        IdxFlags: begin
          flags_d = byte_i;
          idx_d   = IdxDx;
        end
        IdxDx: begin
          dx_d  = byte_i;
          idx_d = IdxDy;
        end
        IdxDy: begin
          push_o = 1'b1;
          idx_d  = IdxFlags;
        end
        default: begin
          idx_d = IdxFlags;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= IdxFlags;
      flags_q <= '0;
      dx_q    <= '0;
    end else begin
      idx_q   <= idx_d;
      flags_q <= flags_d;
      dx_q    <= dx_d;
    end
  end

endmodule

// ===== sv/pmct_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet queue
// Short first-in first-out buffer between the assembler and the cursor unit.
// ----------------------------------------------------------------------------
module pmct_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pmct_pkg::packet_t pkt_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pmct_pkg::packet_t pkt_o
);
  import pmct_pkg::*;

  localparam int unsigned Aw = (QDepth > 1) ? $clog2(QDepth) : 1;

  packet_t        mem_q [QDepth];
  logic [Aw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [Aw:0]    cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign pkt_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Aw'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Aw'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/pmct_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor unit
// Applies packet deltas to the cursor and holds the result for the output.
// ----------------------------------------------------------------------------
module pmct_back #(
  parameter int unsigned TEXT_COLUMNS = 80,
  parameter int unsigned TEXT_ROWS    = 25,
  parameter int unsigned COORD_BITS   = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pmct_pkg::cfg_t             cfg_i,
  input  logic                       recenter_i,
  input  logic                       pkt_valid_i,
  input  pmct_pkg::packet_t          pkt_i,
  output logic                       pkt_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pmct_pkg::OutW-1:0]  cursor_x_o,
  output logic [pmct_pkg::OutW-1:0]  cursor_y_o,
  output logic                       moved_o
);
  import pmct_pkg::*;

  localparam int unsigned PW = COORD_BITS;
  localparam int unsigned SW = COORD_BITS + 2;
  localparam logic [16:0]  DimLim = 17'(1) << COORD_BITS;
  localparam logic [PW-1:0] ColMax = PW'(TEXT_COLUMNS - 1);
  localparam logic [PW-1:0] RowMax = PW'(TEXT_ROWS - 1);
  localparam logic [PW-1:0] ColCtr = PW'(TEXT_COLUMNS / 2);
  localparam logic [PW-1:0] RowCtr = PW'(TEXT_ROWS / 2);

  function automatic logic [16:0] eff_dim(input logic [CfgDataW-1:0] v);
    logic [16:0] w;
    w = 17'(v);
    if (w < 17'd2) begin
      w = 17'd2;
    end else if (w > DimLim) begin
      w = DimLim;
    end
    return w;
  endfunction

  logic [PW-1:0]      pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [15:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic               out_valid_q;
  logic [OutW-1:0]    out_x_q, out_y_q;
  logic               moved_q, moved_d;

  logic [16:0]        eff_w, eff_h;
  logic signed [SW-1:0] max_x, max_y, sum_x, sum_y;
  logic [PW-1:0]      pix_x, pix_y, txt_x, txt_y;
  logic signed [16:0] asum_x, asum_y;
  logic signed [15:0] sat_x, sat_y;
  logic               up_x, dn_x, up_y, dn_y;
  logic signed [15:0] acc_x_n, acc_y_n;

  assign pkt_pop_o   = pkt_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign cursor_x_o  = out_x_q;
  assign cursor_y_o  = out_y_q;
  assign moved_o     = moved_q;

  // Pixel mode: add delta and clamp to the visible area
  always_comb begin
    eff_w = eff_dim(cfg_i.width);
    eff_h = eff_dim(cfg_i.height);
    max_x = signed'(SW'(eff_w - 17'd2));
    max_y = signed'(SW'(eff_h - 17'd2));
    sum_x = signed'(SW'(pos_x_q)) + SW'(pkt_i.dx);
    sum_y = signed'(SW'(pos_y_q)) + SW'(pkt_i.dy);
    if (sum_x < 0) begin
      pix_x = '0;
    end else if (sum_x > max_x) begin
      pix_x = PW'(max_x);
    end else begin
      pix_x = PW'(sum_x);
    end
    if (sum_y < 0) begin
      pix_y = '0;
    end else if (sum_y > max_y) begin
      pix_y = PW'(max_y);
    end else begin
      pix_y = PW'(sum_y);
    end
  end

  // Text mode: saturate accumulators, step at most one cell per axis
  always_comb begin
    asum_x = 17'(acc_x_q) + 17'(pkt_i.dx);
    asum_y = 17'(acc_y_q) + 17'(pkt_i.dy);
    if (asum_x > AccMax) begin
      sat_x = AccMax[15:0];
    end else if (asum_x < AccMin) begin
      sat_x = AccMin[15:0];
    end else begin
      sat_x = asum_x[15:0];
    end
    if (asum_y > AccMax) begin
      sat_y = AccMax[15:0];
    end else if (asum_y < AccMin) begin
      sat_y = AccMin[15:0];
    end else begin
      sat_y = asum_y[15:0];
    end
    up_x    = (sat_x >= AccStepX);
    dn_x    = (sat_x <= -AccStepX);
    up_y    = (sat_y >= AccStepY);
    dn_y    = (sat_y <= -AccStepY);
    acc_x_n = up_x ? sat_x - AccStepX : (dn_x ? sat_x + AccStepX : sat_x);
    acc_y_n = up_y ? sat_y - AccStepY : (dn_y ? sat_y + AccStepY : sat_y);
    txt_x = pos_x_q;
    txt_y = pos_y_q;
    if (up_x && (pos_x_q < ColMax)) begin
      txt_x = pos_x_q + 1'b1;
    end else if (dn_x && (pos_x_q != '0)) begin
      txt_x = pos_x_q - 1'b1;
    end
    if (up_y && (pos_y_q < RowMax)) begin
      txt_y = pos_y_q + 1'b1;
    end else if (dn_y && (pos_y_q != '0)) begin
      txt_y = pos_y_q - 1'b1;
    end
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    if (recenter_i) begin
      pos_x_d = cfg_i.graphical ? PW'(eff_w >> 1) : ColCtr;
      pos_y_d = cfg_i.graphical ? PW'(eff_h >> 1) : RowCtr;
      acc_x_d = '0;
      acc_y_d = '0;
    end else if (pkt_pop_o && !pkt_i.zero) begin
      if (cfg_i.graphical) begin
        pos_x_d = pix_x;
        pos_y_d = pix_y;
      end else begin
        pos_x_d = txt_x;
        pos_y_d = txt_y;
        acc_x_d = acc_x_n;
        acc_y_d = acc_y_n;
      end
    end
    moved_d = (pos_x_d != pos_x_q) || (pos_y_d != pos_y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= ColCtr;
      pos_y_q     <= RowCtr;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
      if (pkt_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_pop_o) begin
      out_x_q <= OutW'(pos_x_d);
      out_y_q <= OutW'(pos_y_d);
      moved_q <= moved_d;
    end
  end

endmodule

// ===== sv/ps2_mouse_cursor_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Decodes 3-byte mouse packets and tracks a pixel or text cell cursor.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the last byte of a packet stalls only while
// the two-entry packet queue is full, which happens under output backpressure.
// Path: the packet enters the queue when its last byte is transferred; the
// cursor unit then pops it, updates the position and loads the output
// register, raising valid, as soon as that register is empty or being read.
// Reset: asynchronous, active low; cursor at the text grid center, width
// 1024, height 768, text mode, accumulators and byte counter cleared.
module ps2_mouse_cursor_tracker #(
  parameter int unsigned TEXT_COLUMNS = 80,
  parameter int unsigned TEXT_ROWS    = 25,
  parameter int unsigned COORD_BITS   = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Byte stream from the mouse
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pmct_pkg::ByteW-1:0]        s_axis_tdata,   // [7:0] data_byte
  // Cursor results, one per packet
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pmct_pkg::OutDataW-1:0]     m_axis_tdata,   // [11:0] cursor_x,
                                                            // [23:12] cursor_y,
                                                            // [24] moved
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pmct_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pmct_pkg::CfgDataW-1:0]     cfg_data_i
);
  import pmct_pkg::*;

  cfg_t            cfg_q, cfg_d;
  logic            cfg_hit;

  logic            q_push, q_full, q_valid, q_pop;
  packet_t         q_in, q_out;

  logic [OutW-1:0] cur_x, cur_y;
  logic            moved;

  // Configuration: always ready; a write to a known register recenters
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d   = cfg_q;
    cfg_hit = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegGraphical: begin
          cfg_d.graphical = cfg_data_i[0];
          cfg_hit         = 1'b1;
        end
        RegWidth: begin
          cfg_d.width = cfg_data_i;
          cfg_hit     = 1'b1;
        end
        RegHeight: begin
          cfg_d.height = cfg_data_i;
          cfg_hit      = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.graphical <= 1'b0;
      cfg_q.width     <= WidthRst;
      cfg_q.height    <= HeightRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: gather bytes into packets and push complete ones
  pmct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (cfg_hit),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .push_o       (q_push),
    .pkt_o        (q_in),
    .q_full_i     (q_full)
  );

  // Queue: decouple packet assembly from cursor update and output stall
  pmct_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pkt_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .pkt_o   (q_out)
  );

  // Back: move the cursor and hold the result until it is transferred
  pmct_back #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_d),
    .recenter_i  (cfg_hit),
    .pkt_valid_i (q_valid),
    .pkt_i       (q_out),
    .pkt_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cursor_x_o  (cur_x),
    .cursor_y_o  (cur_y),
    .moved_o     (moved)
  );

  // Pack result fields from the lowest bit up, zero fill to a whole word
  assign m_axis_tdata = {(OutDataW - 2 * OutW - 1)'(0), moved, cur_y, cur_x};

  // The assembler never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("packet pushed into a full queue");

  // The cursor unit only pops a packet that is present
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("packet popped from an empty queue");

  // A popped packet always shows up at the output next cycle
  a_pop_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid)
    else $error("popped packet produced no result");

  // In text mode the reported column stays inside the grid
  a_text_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !cfg_q.graphical) |-> (cur_x < TEXT_COLUMNS))
    else $error("text cursor column outside the grid");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker testbench
// Streams mouse bytes under random flow control on both sides and predicts
// the cursor result of every 3-byte packet. Text and pixel modes are covered,
// along with edge clamping, accumulator saturation and register writes.
// ----------------------------------------------------------------------------
module tb;
  import pmct_pkg::*;

  localparam int Columns     = 80;
  localparam int Rows        = 25;
  localparam int CoordLimit  = 4096;
  localparam int DrainCycles = 8;    // result latency plus margin
  localparam int HoldCycles  = 300;  // long receiver hold-off

  typedef struct packed {
    logic [OutW-1:0] x;
    logic [OutW-1:0] y;
    logic            moved;
  } cursor_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;    // [7:0] data_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;    // [11:0] cursor_x, [23:12] cursor_y,
                                        // [24] moved
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ps2_mouse_cursor_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Cursor model state
  logic                mode_gfx;
  logic [CfgDataW-1:0] width_reg;
  logic [CfgDataW-1:0] height_reg;
  int                  pkt_phase;
  logic [7:0]          pkt_flags;
  logic [7:0]          pkt_dx;
  int                  cur_x;
  int                  cur_y;
  int                  acc_x;
  int                  acc_y;

  cursor_t cursor_q[$];   // predicted cursor results, oldest first
  int      errors;
  logic    idle_on;       // sender inserts gaps between bursts
  int      burst_left;
  logic    hold_request;  // ask the receiver for a long hold-off

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Cursor model
  // --------------------------------------------------------------------------
  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Screen size as used: saturated to 2..4096
  function automatic int screen_dim(logic [CfgDataW-1:0] v);
    return clamp(int'(v), 2, CoordLimit);
  endfunction

  task automatic recenter_model();
    if (mode_gfx) begin
      cur_x = screen_dim(width_reg) / 2;
      cur_y = screen_dim(height_reg) / 2;
    end else begin
      cur_x = Columns / 2;
      cur_y = Rows / 2;
    end
    pkt_phase = 0;
    pkt_flags = '0;
    pkt_dx    = '0;
    acc_x     = 0;
    acc_y     = 0;
  endtask

  task automatic model_config(input logic [CfgIdxW-1:0] idx,
                              input logic [CfgDataW-1:0] val);
    case (idx)
      RegGraphical: mode_gfx   = val[0];
      RegWidth:     width_reg  = val;
      RegHeight:    height_reg = val;
      default:      return;   // unmapped index: no effect, no recenter
    endcase
    recenter_model();
  endtask

  task automatic model_byte(input logic [7:0] b);
    int      dx;
    int      dy;
    int      old_x;
    int      old_y;
    int      sx;
    int      sy;
    cursor_t res;
    if (pkt_phase == 0) begin
      pkt_flags = b;
      pkt_phase = 1;
      return;
    end
    if (pkt_phase == 1) begin
      pkt_dx    = b;
      pkt_phase = 2;
      return;
    end
    pkt_phase = 0;
    dx = int'(pkt_dx) - (pkt_flags[FlagSignX] ? 256 : 0);
    dy = -(int'(b) - (pkt_flags[FlagSignY] ? 256 : 0));
    old_x = cur_x;
    old_y = cur_y;
    // An all-zero delta leaves position and accumulators alone
    if (dx != 0 || dy != 0) begin
      if (mode_gfx) begin
        cur_x = clamp(cur_x + dx, 0, screen_dim(width_reg) - 2);
        cur_y = clamp(cur_y + dy, 0, screen_dim(height_reg) - 2);
      end else begin
        sx = 0;
        sy = 0;
        acc_x = clamp(acc_x + dx, int'(AccMin), int'(AccMax));
        acc_y = clamp(acc_y + dy, int'(AccMin), int'(AccMax));
        if (acc_x >= int'(AccStepX)) begin sx = 1;  acc_x -= int'(AccStepX); end
        if (acc_x <= -int'(AccStepX)) begin sx = -1; acc_x += int'(AccStepX); end
        if (acc_y >= int'(AccStepY)) begin sy = 1;  acc_y -= int'(AccStepY); end
        if (acc_y <= -int'(AccStepY)) begin sy = -1; acc_y += int'(AccStepY); end
        cur_x = clamp(cur_x + sx, 0, Columns - 1);
        cur_y = clamp(cur_y + sy, 0, Rows - 1);
      end
    end
    res.x     = cur_x[OutW-1:0];
    res.y     = cur_y[OutW-1:0];
    res.moved = (cur_x != old_x) || (cur_y != old_y);
    cursor_q.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Byte sender and register writer
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    model_byte(b);
  endtask

  task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_byte(flags);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Drop valid, wait for every result, then let a packet still in flight finish
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (cursor_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    model_config(idx, val);
  endtask

  // 9-bit two's complement delta, steered by bias (-1, 0, +1)
  function automatic logic [8:0] rand_delta(int bias);
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = $urandom_range(0, 1) ? 255 : -256;
      default: v = int'($urandom_range(0, 40)) - 20 + bias * int'($urandom_range(0, 30));
    endcase
    return v[8:0];
  endfunction

  // Packets drifting one way for the first half and back for the second,
  // with some zero-delta and some fully random packets mixed in
  task automatic run_moves(input int packets);
    logic [7:0] flags;
    logic [8:0] dx;
    logic [8:0] dy;
    int         dir;
    for (int i = 0; i < packets; i++) begin
      dir   = (i < packets / 2) ? 1 : -1;
      flags = 8'($urandom);
      case ($urandom_range(0, 9))
        0: begin
          flags[FlagSignX] = 1'b0;
          flags[FlagSignY] = 1'b0;
          send_packet(flags, 8'h00, 8'h00);
        end
        1: send_packet(flags, 8'($urandom), 8'($urandom));
        default: begin
          dx = rand_delta(dir);
          dy = rand_delta(-dir);
          flags[FlagSignX] = dx[8];
          flags[FlagSignY] = dy[8];
          send_packet(flags, dx[7:0], dy[7:0]);
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker with its own stall pattern and long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_check
    logic [15:0] stall_pat;
    int          cyc;
    int          hold_left;
    cursor_t     want;
    cursor_t     got;
    m_axis_tready = 1'b0;
    stall_pat     = 16'hFFFF;
    cyc           = 0;
    hold_left     = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.x     = m_axis_tdata[11:0];
        got.y     = m_axis_tdata[23:12];
        got.moved = m_axis_tdata[24];
        if (cursor_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%0d y=%0d moved=%0b",
                   $time, got.x, got.y, got.moved);
        end else begin
          want = cursor_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected x=%0d y=%0d moved=%0b, actual x=%0d y=%0d moved=%0b",
                     $time, want.x, want.y, want.moved, got.x, got.y, got.moved);
          end
        end
      end
      cyc++;
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      // Pick a new stall pattern now and then; all-ones gives clean stretches
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = 16'hFFFF;
          1:       stall_pat = 16'hF0F3;
          default: stall_pat = 16'($urandom) | 16'h0001;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= stall_pat[cyc % 16];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Text grid from reset: zero packet, sub-step delta, single steps, extremes
  task automatic test_text_basics();
    send_packet(8'h00, 8'h00, 8'h00);  // zero delta, no move
    send_packet(8'h08, 8'h03, 8'h00);  // delta below one cell
    send_packet(8'h08, 8'h01, 8'h00);  // completes one cell
    send_packet(8'h30, 8'h00, 8'h00);  // most negative X, most positive Y
    send_packet(8'hFF, 8'hFF, 8'hFF);  // minus one on both raw deltas
    send_packet(8'h0F, 8'hFF, 8'h80);  // largest positive X, positive raw Y
  endtask

  // Mode and screen size registers, their extremes and the unmapped index
  task automatic test_config_regs();
    write_reg(RegGraphical, 13'h0001);
    send_packet(8'h20, 8'h7F, 8'h01);
    write_reg(RegWidth, 13'd0);        // saturates to 2
    write_reg(RegHeight, 13'd1);
    send_packet(8'h00, 8'h05, 8'hF0);  // clamped at zero on both axes
    write_reg(CfgIdxW'(3), 13'h1FFF);  // no register, no recenter
    send_packet(8'h00, 8'h00, 8'h00);
    write_reg(RegWidth, 13'h1FFF);     // saturates to 4096
    write_reg(RegHeight, 13'd4097);
    send_packet(8'h10, 8'h00, 8'hFF);
    write_reg(RegWidth, 13'd4096);
    write_reg(RegHeight, 13'd2);
    send_packet(8'h00, 8'hFF, 8'h00);
  endtask

  // Drive the text accumulators into both saturation limits, then back off
  task automatic test_text_saturation();
    logic [7:0] flags;
    write_reg(RegGraphical, {12'($urandom_range(0, 4095)), 1'b0});
    for (int i = 0; i < 140; i++) begin
      flags = 8'($urandom);
      flags[FlagSignX] = 1'b0;
      flags[FlagSignY] = 1'b0;
      send_packet(flags, 8'($urandom_range(230, 255)), 8'($urandom_range(230, 255)));
    end
    for (int i = 0; i < 6; i++) begin
      flags = 8'($urandom);
      flags[FlagSignX] = 1'b1;
      flags[FlagSignY] = 1'b1;
      send_packet(flags, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_graphical_random();
    logic [CfgDataW-1:0] widths[5]  = '{13'd1024, 13'h1FFF, 13'd2, 13'd37, 13'd4097};
    logic [CfgDataW-1:0] heights[5] = '{13'd768, 13'h1FFF, 13'd3, 13'd4096, 13'd0};
    for (int k = 0; k < 5; k++) begin
      write_reg(RegWidth, widths[k]);
      write_reg(RegHeight, heights[k]);
      write_reg(RegGraphical, {12'($urandom_range(0, 4095)), 1'b1});
      run_moves(40);
    end
  endtask

  task automatic test_text_random();
    write_reg(RegGraphical, {12'($urandom_range(0, 4095)), 1'b0});
    run_moves(50);
  endtask

  // Raw bytes with no packet structure, left misaligned
  task automatic test_byte_noise();
    for (int i = 0; i < 61; i++) send_byte(8'($urandom));
  endtask

  // Hold the receiver off while the sender streams without gaps
  task automatic test_backpressure();
    write_reg(RegGraphical, {12'($urandom_range(0, 4095)), 1'b1});
    idle_on      = 1'b0;
    hold_request = 1'b1;
    run_moves(30);
    idle_on      = 1'b1;
  endtask

  initial begin : stimulus
    errors        = 0;
    idle_on       = 1'b1;
    burst_left    = 0;
    hold_request  = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegGraphical;
    cfg_data_i    = '0;
    mode_gfx      = 1'b0;
    width_reg     = WidthRst;
    height_reg    = HeightRst;
    recenter_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_text_basics();
    test_config_regs();
    test_text_saturation();
    test_graphical_random();
    test_text_random();
    test_byte_noise();
    test_backpressure();

    wait_drained();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pmct_pkg.sv
sv/pmct_front.sv
sv/pmct_fifo.sv
sv/pmct_back.sv
sv/ps2_mouse_cursor_tracker.sv
tb/sv/tb.sv
